[sv/cmvm_pkg.sv]
// Package of constants, types and helpers for the crossbar matrix-vector multiply block.
package cmvm_pkg;

    // Storage geometry
    localparam int NUM_CROSSBARS = 16;
    localparam int MAX_ROWS      = 32;
    localparam int MAX_COLS      = 32;
    localparam int RESULT_LIMIT  = 32;

    localparam int W_DEPTH = NUM_CROSSBARS * MAX_ROWS * MAX_COLS;
    localparam int WA_W    = $clog2(W_DEPTH);
    localparam int ROW_W   = $clog2(MAX_ROWS);
    localparam int ROWS_CAP = (MAX_ROWS < RESULT_LIMIT) ? MAX_ROWS : RESULT_LIMIT;

    // Operation codes
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_ELEM  = 1'b1;

    // Configuration register indexes
    localparam logic CFG_OUT_COUNT = 1'b0;
    localparam logic CFG_ELEM_MODE = 1'b1;

    // Element width codes
    localparam logic [1:0] EM_8  = 2'd0;
    localparam logic [1:0] EM_16 = 2'd1;
    localparam logic [1:0] EM_32 = 2'd2;
    localparam logic [1:0] EM_64 = 2'd3;

    typedef logic [WA_W-1:0]  t_waddr;
    typedef logic [ROW_W-1:0] t_row;

    // Controller states
    typedef enum logic [4:0] {
        ST_IDLE    = 5'b00001,
        ST_MAC     = 5'b00010,
        ST_DRAIN   = 5'b00100,
        ST_EMIT_RD = 5'b01000,
        ST_EMIT_WR = 5'b10000
    } t_state;

    // Flat weight address of (crossbar, row, column)
    function automatic t_waddr weight_addr(input logic [3:0] xbar, input logic [4:0] row,
                                           input logic [4:0] col);
        int a;
        a = (int'(xbar) * MAX_ROWS + int'(row)) * MAX_COLS + int'(col);
        return WA_W'(a);
    endfunction

    // Wrap to the selected signed width and sign-extend
    function automatic logic [63:0] wrap_sum(input logic [63:0] v, input logic [1:0] mode);
        logic [63:0] r;
        unique case (mode)
            EM_8:    r = {{56{v[7]}},  v[7:0]};
            EM_16:   r = {{48{v[15]}}, v[15:0]};
            EM_32:   r = {{32{v[31]}}, v[31:0]};
            default: r = v;
        endcase
        return r;
    endfunction

endpackage

[sv/crossbar_matrix_vector_multiply.sv]
// Top level of the crossbar matrix-vector multiply block.
// Weights for every crossbar sit in one synchronous memory of
// NUM_CROSSBARS*MAX_ROWS*MAX_COLS 64-bit words; the row accumulators sit in a second
// memory of MAX_ROWS words with a valid bit per row, so they read as zero after reset
// and after each vector. For a vector element, the weight memory is read once per row
// in use and every product passes a multiply-accumulate pipeline (weight read, 32-bit
// partial products, product combine and accumulator read, accumulator write). On an
// element marked last, the results follow, one accumulator read per result, through an
// output register; the next input transaction is taken while the final result still
// waits there. Arithmetic is kept at 64 bits and wrapped to the selected element
// width only as a result leaves.
module crossbar_matrix_vector_multiply import cmvm_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [5:0]  i_cfg_data,
    // input channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_operation,
    input  logic [3:0]  i_crossbar,
    input  logic [4:0]  i_row_index,
    input  logic [4:0]  i_col_index,
    input  logic [63:0] i_value,
    input  logic        i_last_element,
    // output channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [63:0] o_sum,
    output logic [4:0]  o_out_row,
    output logic        o_last_result
);

    // Configuration registers
    logic [5:0] r_out_count;
    logic [1:0] r_elem_mode;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_count <= 6'd32;
            r_elem_mode <= EM_64;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_OUT_COUNT: r_out_count <= i_cfg_data;
                CFG_ELEM_MODE: r_elem_mode <= i_cfg_data[1:0];
                default: ;
            endcase
        end
    end

    // Rows in use, clamped
    logic [5:0] w_rows;
    always_comb begin
        if (r_out_count == 6'd0)
            w_rows = 6'd1;
        else if (int'(r_out_count) > ROWS_CAP)
            w_rows = 6'(ROWS_CAP);
        else
            w_rows = r_out_count;
    end

    // Controller state and item registers
    t_state      r_state;
    t_row        r_row;
    logic [63:0] r_elem;
    logic [3:0]  r_xbar;
    logic [4:0]  r_col;
    logic        r_last;

    logic w_in_acc;
    logic w_row_end;
    logic w_elem_ok;
    logic w_wr_ok;
    logic w_out_free;

    assign o_in_stall = (r_state != ST_IDLE);
    assign w_in_acc   = i_in_valid && !o_in_stall;
    assign w_row_end  = (r_row == ROW_W'(w_rows - 6'd1));
    assign w_elem_ok  = (int'(i_crossbar) < NUM_CROSSBARS) && (int'(i_col_index) < MAX_COLS);
    assign w_wr_ok    = w_elem_ok && (int'(i_row_index) < MAX_ROWS);
    assign w_out_free = !o_out_valid || !i_out_stall;

    // Weight memory
    logic [63:0] weight_mem [W_DEPTH];
    logic [63:0] r_w_rdata;
    logic        w_w_we;
    logic        w_w_re;

    assign w_w_we = w_in_acc && (i_operation == OP_WRITE) && w_wr_ok;
    assign w_w_re = (r_state == ST_MAC);

    always_ff @(posedge i_clk) begin
        if (w_w_we)
            weight_mem[weight_addr(i_crossbar, i_row_index, i_col_index)] <= i_value;
        if (w_w_re)
            r_w_rdata <= weight_mem[weight_addr(r_xbar, 5'(r_row), r_col)];
    end

    // Pipeline control: valid and row of each stage
    logic r_v1, r_v2, r_v3;
    t_row r_row1, r_row2, r_row3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= w_w_re;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
        r_row1 <= r_row;
        r_row2 <= r_row1;
        r_row3 <= r_row2;
    end

    // Partial products of the low 64 bits of element * weight
    logic [63:0] n_pll;
    logic [31:0] n_px1, n_px2;
    logic [63:0] r_pll;
    logic [31:0] r_px1, r_px2;
    logic [63:0] n_prod;
    logic [63:0] r_prod;

    assign n_pll  = 64'(r_elem[31:0]) * 64'(r_w_rdata[31:0]);
    assign n_px1  = r_elem[63:32] * r_w_rdata[31:0];
    assign n_px2  = r_elem[31:0]  * r_w_rdata[63:32];
    assign n_prod = r_pll + {r_px1 + r_px2, 32'b0};

    always_ff @(posedge i_clk) begin
        r_pll  <= n_pll;
        r_px1  <= n_px1;
        r_px2  <= n_px2;
        r_prod <= n_prod;
    end

    // Accumulator memory with per-row valid bits
    logic [63:0] acc_mem [MAX_ROWS];
    logic [MAX_ROWS-1:0] r_acc_vld;
    logic [63:0] r_acc_rdata;
    logic        r_acc_rvld;
    logic        w_acc_re;
    t_row        w_acc_raddr;
    logic [63:0] w_acc_old;
    logic        w_clear;

    assign w_acc_re    = r_v2 || (r_state == ST_EMIT_RD);
    assign w_acc_raddr = r_v2 ? r_row2 : r_row;
    assign w_acc_old   = r_acc_rvld ? r_acc_rdata : 64'd0;
    assign w_clear     = (r_state == ST_EMIT_WR) && w_out_free && w_row_end;

    always_ff @(posedge i_clk) begin
        if (r_v3)
            acc_mem[r_row3] <= w_acc_old + r_prod;
        if (w_acc_re) begin
            r_acc_rdata <= acc_mem[w_acc_raddr];
            r_acc_rvld  <= r_acc_vld[w_acc_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_acc_vld <= '0;
        else if (w_clear)
            r_acc_vld <= '0;
        else if (r_v3)
            r_acc_vld[r_row3] <= 1'b1;
    end

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_row   <= '0;
            r_last  <= 1'b0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (w_in_acc && (i_operation == OP_ELEM)) begin
                        r_row  <= '0;
                        r_last <= i_last_element;
                        if (w_elem_ok)
                            r_state <= ST_MAC;
                        else if (i_last_element)
                            r_state <= ST_EMIT_RD;
                    end
                end
                ST_MAC: begin
                    if (w_row_end) begin
                        r_row   <= '0;
                        r_state <= ST_DRAIN;
                    end else begin
                        r_row <= r_row + t_row'(1);
                    end
                end
                ST_DRAIN: begin
                    if (!r_v1 && !r_v2 && !r_v3)
                        r_state <= r_last ? ST_EMIT_RD : ST_IDLE;
                end
                ST_EMIT_RD: begin
                    r_state <= ST_EMIT_WR;
                end
                ST_EMIT_WR: begin
                    if (w_out_free) begin
                        if (w_row_end) begin
                            r_state <= ST_IDLE;
                        end else begin
                            r_row   <= r_row + t_row'(1);
                            r_state <= ST_EMIT_RD;
                        end
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // Element operands held for the whole pass
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_elem <= i_value;
            r_xbar <= i_crossbar;
            r_col  <= i_col_index;
        end
    end

    // Output register
    logic        r_out_valid;
    logic [63:0] r_sum;
    logic [4:0]  r_out_row;
    logic        r_last_res;
    logic        w_out_load;

    assign w_out_load = (r_state == ST_EMIT_WR) && w_out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_out_valid <= 1'b0;
        else if (w_out_load)
            r_out_valid <= 1'b1;
        else if (!i_out_stall)
            r_out_valid <= 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_sum      <= wrap_sum(w_acc_old, r_elem_mode);
            r_out_row  <= 5'(r_row);
            r_last_res <= w_row_end;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_sum         = r_sum;
    assign o_out_row     = r_out_row;
    assign o_last_result = r_last_res;

endmodule
